/* hw/rtl/mlm_pkg.sv */
// package: types and constants shared by the mutex lock manager
`default_nettype none

package mlm_pkg;

  localparam int unsigned OP_W  = 3;
  localparam int unsigned IDX_W = 4;
  localparam int unsigned TID_W = 4;
  localparam int unsigned ST_W  = 2;

  typedef enum logic [OP_W-1:0] {
    OP_INIT    = 3'd0,
    OP_LOCK    = 3'd1,
    OP_TRYLOCK = 3'd2,
    OP_UNLOCK  = 3'd3,
    OP_DESTROY = 3'd4
  } op_e;

  localparam logic [ST_W-1:0] ST_OK   = 2'd0;
  localparam logic [ST_W-1:0] ST_BUSY = 2'd1;
  localparam logic [ST_W-1:0] ST_WAIT = 2'd2;
  localparam logic [ST_W-1:0] ST_ERR  = 2'd3;

  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_LOOK = 2'd1,
    S_LINK = 2'd2
  } state_e;

  // per-mutex record kept in the mutex table
  typedef struct packed {
    logic             init;
    logic             lck;
    logic             cnf;
    logic [TID_W-1:0] own;
    logic             qne;
    logic [TID_W-1:0] head;
    logic [TID_W-1:0] tail;
  } rec_t;

  typedef struct packed {
    logic capture;
    logic link_rd;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic need_link;
  } sts_t;

endpackage

`default_nettype wire

/* hw/rtl/mlm_if.sv */
// interfaces: request and response channels of the mutex lock manager
`default_nettype none

interface mlm_req_if;
  logic                           valid;
  logic                           ready;
  logic [mlm_pkg::OP_W-1:0]       operation;
  logic [mlm_pkg::IDX_W-1:0]      mutex_index;
  logic [mlm_pkg::TID_W-1:0]      thread_id;
  logic                           plain_type;

  modport source (output valid, operation, mutex_index, thread_id, plain_type,
                  input ready);
  modport sink (input valid, operation, mutex_index, thread_id, plain_type,
                output ready);
endinterface

interface mlm_rsp_if;
  logic                           valid;
  logic                           ready;
  logic [mlm_pkg::ST_W-1:0]       status;
  logic                           woken_valid;
  logic [mlm_pkg::TID_W-1:0]      woken_thread;

  modport source (output valid, status, woken_valid, woken_thread, input ready);
  modport sink (input valid, status, woken_valid, woken_thread, output ready);
endinterface

`default_nettype wire

/* hw/rtl/mlm_ram.sv */
// generic single-write, single-read ram with registered read data
`default_nettype none

module mlm_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

/* hw/rtl/mlm_ctrl.sv */
// controller: sequences table lookup, waiter link read and commit
`default_nettype none

module mlm_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  input  wire mlm_pkg::sts_t sts_i,
  output mlm_pkg::cmd_t      cmd_o
);

  mlm_pkg::state_e state_q, state_d;
  logic            out_valid_q, out_valid_d;
  logic            slot_free;

  assign slot_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= mlm_pkg::S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      mlm_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = mlm_pkg::S_LOOK;
        end
      end
      mlm_pkg::S_LOOK: begin
        if (sts_i.need_link) begin
          cmd_o.link_rd = 1'b1;
          state_d       = mlm_pkg::S_LINK;
        end else if (slot_free) begin
          cmd_o.commit = 1'b1;
          state_d      = mlm_pkg::S_IDLE;
        end
      end
      mlm_pkg::S_LINK: begin
        if (slot_free) begin
          cmd_o.commit = 1'b1;
          state_d      = mlm_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = mlm_pkg::S_IDLE;
      end
    endcase

    if (cmd_o.commit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  assign out_valid_o = out_valid_q;

`ifndef SYNTH
  a_accept_to_look: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> state_q == mlm_pkg::S_LOOK)
    else $error("accepted beat did not start a table lookup");

  a_commit_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.commit |=> out_valid_q)
    else $error("committed result not presented on the response channel");

  a_link_from_look: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == mlm_pkg::S_LINK |->
      ($past(state_q) == mlm_pkg::S_LOOK || $past(state_q) == mlm_pkg::S_LINK))
    else $error("link read state entered without a lookup");
`endif

endmodule

`default_nettype wire

/* hw/rtl/mlm_dp.sv */
// datapath: mutex table, waiter links, request decode and result register
`default_nettype none

module mlm_dp #(
  parameter int unsigned NUM_MUTEXES = 16,
  parameter int unsigned NUM_THREADS = 16
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire mlm_pkg::cmd_t               cmd_i,
  output mlm_pkg::sts_t                    sts_o,
  input  wire logic [mlm_pkg::OP_W-1:0]    operation_i,
  input  wire logic [mlm_pkg::IDX_W-1:0]   mutex_index_i,
  input  wire logic [mlm_pkg::TID_W-1:0]   thread_id_i,
  input  wire logic                        plain_type_i,
  output logic      [mlm_pkg::ST_W-1:0]    status_o,
  output logic                             woken_valid_o,
  output logic      [mlm_pkg::TID_W-1:0]   woken_thread_o
);

  localparam int unsigned MAW   = (NUM_MUTEXES > 1) ? $clog2(NUM_MUTEXES) : 1;
  localparam int unsigned TAW   = $clog2(NUM_THREADS);
  localparam int unsigned REC_W = $bits(mlm_pkg::rec_t);
  localparam int unsigned TID_W = mlm_pkg::TID_W;

  // captured request
  logic [mlm_pkg::OP_W-1:0]  op_q;
  logic [mlm_pkg::IDX_W-1:0] mi_q;
  logic [TID_W-1:0]          tid_q;
  logic                      plain_q;

  // entries never written read as the reset record
  logic [NUM_MUTEXES-1:0] valid_q;

  logic [REC_W-1:0]  rec_raw;
  logic [TID_W-1:0]  link_rdata;
  mlm_pkg::rec_t     rec, rec_new;
  logic              idx_ok, rec_we, link_we, need_link;
  logic [MAW-1:0]    rd_maddr, mi_addr;
  logic [mlm_pkg::ST_W-1:0] st;
  logic              wv;
  logic [TID_W-1:0]  wt;

  logic [mlm_pkg::ST_W-1:0] status_q;
  logic                     woken_valid_q;
  logic [TID_W-1:0]         woken_thread_q;

  assign mi_addr  = MAW'(mi_q);
  assign rd_maddr = MAW'(mutex_index_i);

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q    <= operation_i;
      mi_q    <= mutex_index_i;
      tid_q   <= thread_id_i;
      plain_q <= plain_type_i;
    end
    if (cmd_i.commit) begin
      status_q       <= st;
      woken_valid_q  <= wv;
      woken_thread_q <= wt;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (rec_we) begin
      valid_q[mi_addr] <= 1'b1;
    end
  end

  mlm_ram #(
    .WIDTH (REC_W),
    .DEPTH (NUM_MUTEXES)
  ) u_mutex_tab (
    .clk_i   (clk_i),
    .we_i    (rec_we),
    .waddr_i (mi_addr),
    .wdata_i (rec_new),
    .re_i    (cmd_i.capture),
    .raddr_i (rd_maddr),
    .rdata_o (rec_raw)
  );

  mlm_ram #(
    .WIDTH (TID_W),
    .DEPTH (NUM_THREADS)
  ) u_link_tab (
    .clk_i   (clk_i),
    .we_i    (link_we),
    .waddr_i (TAW'(rec.tail)),
    .wdata_i (tid_q),
    .re_i    (cmd_i.link_rd),
    .raddr_i (TAW'(rec.head)),
    .rdata_o (link_rdata)
  );

  assign rec = valid_q[mi_addr] ? mlm_pkg::rec_t'(rec_raw) : '0;

  assign idx_ok = (32'(mi_q) < NUM_MUTEXES) && (32'(tid_q) < NUM_THREADS);

  always_comb begin
    rec_new   = rec;
    st        = mlm_pkg::ST_ERR;
    wv        = 1'b0;
    wt        = '0;
    link_we   = 1'b0;
    need_link = 1'b0;
    if (idx_ok) begin
      unique case (op_q)
        mlm_pkg::OP_INIT: begin
          if (plain_q && !rec.init) begin
            rec_new.init = 1'b1;
            rec_new.lck  = 1'b0;
            rec_new.cnf  = 1'b0;
            rec_new.own  = '0;
            rec_new.qne  = 1'b0;
            st           = mlm_pkg::ST_OK;
          end
        end
        mlm_pkg::OP_LOCK: begin
          if (rec.init) begin
            if (!rec.lck) begin
              rec_new.lck = 1'b1;
              rec_new.cnf = 1'b0;
              rec_new.own = tid_q;
              st          = mlm_pkg::ST_OK;
            end else begin
              // held: append requester to the wait queue
              rec_new.cnf = 1'b1;
              if (rec.qne) begin
                // link written only with the entry itself
                link_we = cmd_i.commit;
              end else begin
                rec_new.head = tid_q;
              end
              rec_new.tail = tid_q;
              rec_new.qne  = 1'b1;
              st           = mlm_pkg::ST_WAIT;
            end
          end
        end
        mlm_pkg::OP_TRYLOCK: begin
          if (rec.init) begin
            if (!rec.lck) begin
              rec_new.lck = 1'b1;
              rec_new.cnf = 1'b0;
              rec_new.own = tid_q;
              st          = mlm_pkg::ST_OK;
            end else begin
              st = mlm_pkg::ST_BUSY;
            end
          end
        end
        mlm_pkg::OP_UNLOCK: begin
          if (rec.init && rec.lck && rec.own == tid_q) begin
            if (rec.qne) begin
              // hand off to the queue head
              if (rec.head == rec.tail) begin
                rec_new.qne = 1'b0;
              end else begin
                need_link    = 1'b1;
                rec_new.head = link_rdata;
              end
              rec_new.own = rec.head;
              wv          = 1'b1;
              wt          = rec.head;
            end else begin
              rec_new.lck = 1'b0;
              rec_new.cnf = 1'b0;
              rec_new.own = '0;
            end
            st = mlm_pkg::ST_OK;
          end
        end
        mlm_pkg::OP_DESTROY: begin
          if (rec.init && (!rec.lck || (rec.own == tid_q && !rec.cnf))) begin
            rec_new.init = 1'b0;
            rec_new.lck  = 1'b0;
            rec_new.cnf  = 1'b0;
            rec_new.own  = '0;
            rec_new.qne  = 1'b0;
            st           = mlm_pkg::ST_OK;
          end
        end
        default: begin
          st = mlm_pkg::ST_ERR;
        end
      endcase
    end
  end

  assign rec_we          = cmd_i.commit && idx_ok;
  assign sts_o.need_link = need_link;

  assign status_o       = status_q;
  assign woken_valid_o  = woken_valid_q;
  assign woken_thread_o = woken_thread_q;

endmodule

`default_nettype wire

/* hw/rtl/mutex_lock_manager_fifo_handoff.sv */
// top level: mutex lock manager with fifo wait queues and unlock handoff
// a request beat is captured and its mutex table entry read, then the result
//   is committed to the result register; an unlock that hands off to a waiter
//   with others still queued adds a waiter link read before the commit
// a new request beat is taken only after the previous one commits; a commit waits while the last result is unread
// reset: asynchronous active low; all mutexes read as uninitialized, no clearing pass
`default_nettype none

module mutex_lock_manager_fifo_handoff #(
  parameter int unsigned NUM_MUTEXES = 16,
  parameter int unsigned NUM_THREADS = 16
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  mlm_req_if.sink    req_i,
  mlm_rsp_if.source  rsp_o
);

  // command and status between controller and datapath
  mlm_pkg::cmd_t cmd;
  mlm_pkg::sts_t sts;

  // controller: idle -> lookup -> (link read) -> commit
  // the result register frees the request side, so a new beat is taken
  // while the previous result still waits on the response channel
  mlm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_i.valid),
    .in_ready_o  (req_i.ready),
    .out_valid_o (rsp_o.valid),
    .out_ready_i (rsp_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // datapath: mutex table ram with valid bits, shared waiter link ram,
  // decode of the request against the looked-up entry, result register
  mlm_dp #(
    .NUM_MUTEXES (NUM_MUTEXES),
    .NUM_THREADS (NUM_THREADS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .operation_i    (req_i.operation),
    .mutex_index_i  (req_i.mutex_index),
    .thread_id_i    (req_i.thread_id),
    .plain_type_i   (req_i.plain_type),
    .status_o       (rsp_o.status),
    .woken_valid_o  (rsp_o.woken_valid),
    .woken_thread_o (rsp_o.woken_thread)
  );

endmodule

`default_nettype wire

/* test/testbench.sv */
// testbench: directed table and random request streams for the mutex lock manager
`timescale 1ns / 100ps

module testbench;

  localparam int unsigned NUM_MX      = 16;
  localparam int unsigned NUM_TH      = 16;
  localparam int unsigned PHASE_BEATS = 250;  // request beats per random phase
  localparam int unsigned HOLD_CYCLES = 200;  // long receiver hold-off, fills the block
  localparam int unsigned TAIL_CYCLES = 8;    // settle time after the last result

  // operation codes the block must reject
  localparam logic [mlm_pkg::OP_W-1:0] OP_UNDEF5 = 3'd5;
  localparam logic [mlm_pkg::OP_W-1:0] OP_UNDEF6 = 3'd6;
  localparam logic [mlm_pkg::OP_W-1:0] OP_UNDEF7 = 3'd7;

  // table rows either carry a typed status or defer to the predictor
  localparam logic PRED  = 1'b0;
  localparam logic KNOWN = 1'b1;

  typedef logic [mlm_pkg::OP_W-1:0]  opc_t;
  typedef logic [mlm_pkg::IDX_W-1:0] idx_t;
  typedef logic [mlm_pkg::TID_W-1:0] tid_t;

  typedef struct packed {
    logic [mlm_pkg::ST_W-1:0] status;
    logic                     woken_valid;
    tid_t                     woken_thread;
  } rsp_t;

  typedef struct packed {
    opc_t                     op;
    idx_t                     mtx;
    tid_t                     tid;
    logic                     plain;
    logic                     known;
    logic [mlm_pkg::ST_W-1:0] status;  // only meaningful on KNOWN rows, woken fields zero
  } row_t;

  localparam int unsigned N_DIRECTED = 27;
  localparam row_t DIRECTED [N_DIRECTED] = '{
    // requests on a mutex that was never initialized
    '{mlm_pkg::OP_LOCK,    4'd0,  4'd1,  1'b0, KNOWN, mlm_pkg::ST_ERR},
    '{mlm_pkg::OP_UNLOCK,  4'd0,  4'd1,  1'b0, KNOWN, mlm_pkg::ST_ERR},
    '{mlm_pkg::OP_DESTROY, 4'd0,  4'd1,  1'b0, KNOWN, mlm_pkg::ST_ERR},
    // init: wrong type, good, then twice
    '{mlm_pkg::OP_INIT,    4'd0,  4'd0,  1'b0, KNOWN, mlm_pkg::ST_ERR},
    '{mlm_pkg::OP_INIT,    4'd0,  4'd0,  1'b1, KNOWN, mlm_pkg::ST_OK},
    '{mlm_pkg::OP_INIT,    4'd0,  4'd0,  1'b1, KNOWN, mlm_pkg::ST_ERR},
    // unknown operations
    '{OP_UNDEF5,           4'd0,  4'd0,  1'b1, KNOWN, mlm_pkg::ST_ERR},
    '{OP_UNDEF7,           4'd15, 4'd15, 1'b1, KNOWN, mlm_pkg::ST_ERR},
    // top mutex, top thread
    '{mlm_pkg::OP_INIT,    4'd15, 4'd15, 1'b1, KNOWN, mlm_pkg::ST_OK},
    '{mlm_pkg::OP_LOCK,    4'd15, 4'd15, 1'b0, KNOWN, mlm_pkg::ST_OK},
    '{mlm_pkg::OP_TRYLOCK, 4'd15, 4'd3,  1'b0, KNOWN, mlm_pkg::ST_BUSY},
    // owner queues behind itself, then thread 0 queues
    '{mlm_pkg::OP_LOCK,    4'd15, 4'd15, 1'b0, PRED,  mlm_pkg::ST_OK},
    '{mlm_pkg::OP_LOCK,    4'd15, 4'd0,  1'b0, PRED,  mlm_pkg::ST_OK},
    // destroy while contended, unlock by a stranger
    '{mlm_pkg::OP_DESTROY, 4'd15, 4'd15, 1'b0, PRED,  mlm_pkg::ST_OK},
    '{mlm_pkg::OP_UNLOCK,  4'd15, 4'd3,  1'b0, PRED,  mlm_pkg::ST_OK},
    // handoff with a waiter still behind (long path), then the last waiter
    '{mlm_pkg::OP_UNLOCK,  4'd15, 4'd15, 1'b0, PRED,  mlm_pkg::ST_OK},
    '{mlm_pkg::OP_UNLOCK,  4'd15, 4'd15, 1'b0, PRED,  mlm_pkg::ST_OK},
    // full release, then unlock of a free mutex
    '{mlm_pkg::OP_UNLOCK,  4'd15, 4'd0,  1'b0, PRED,  mlm_pkg::ST_OK},
    '{mlm_pkg::OP_UNLOCK,  4'd15, 4'd0,  1'b0, PRED,  mlm_pkg::ST_OK},
    // same thread queued twice on mutex 0
    '{mlm_pkg::OP_LOCK,    4'd0,  4'd5,  1'b0, PRED,  mlm_pkg::ST_OK},
    '{mlm_pkg::OP_LOCK,    4'd0,  4'd10, 1'b0, PRED,  mlm_pkg::ST_OK},
    '{mlm_pkg::OP_LOCK,    4'd0,  4'd10, 1'b0, PRED,  mlm_pkg::ST_OK},
    '{mlm_pkg::OP_UNLOCK,  4'd0,  4'd5,  1'b0, PRED,  mlm_pkg::ST_OK},
    // conflict is sticky across the handoff, so destroy fails until release
    '{mlm_pkg::OP_DESTROY, 4'd0,  4'd10, 1'b0, PRED,  mlm_pkg::ST_OK},
    '{mlm_pkg::OP_UNLOCK,  4'd0,  4'd10, 1'b0, PRED,  mlm_pkg::ST_OK},
    '{mlm_pkg::OP_DESTROY, 4'd0,  4'd10, 1'b0, PRED,  mlm_pkg::ST_OK},
    // destroyed mutex reads as uninitialized again
    '{mlm_pkg::OP_LOCK,    4'd0,  4'd1,  1'b0, KNOWN, mlm_pkg::ST_ERR}
  };

  // clock and reset
  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  always #2 clk_i = ~clk_i;  // 4 ns period

  mlm_req_if req_if ();
  mlm_rsp_if rsp_if ();

  mutex_lock_manager_fifo_handoff i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  // lock table as the predictor sees it; bit types come up zero like the block
  bit   mx_init   [NUM_MX];
  bit   mx_locked [NUM_MX];
  bit   mx_cnf    [NUM_MX];
  tid_t mx_owner  [NUM_MX];
  bit   mx_qne    [NUM_MX];
  tid_t mx_head   [NUM_MX];
  tid_t mx_tail   [NUM_MX];
  tid_t th_next   [NUM_TH];  // waiter link, shared by all queues

  rsp_t        pending_rsp [$];  // results owed by the block, oldest first
  int unsigned mismatch_cnt = 0;

  int unsigned src_idle_pct  = 0;  // sender idle chance per cycle
  int unsigned snk_stall_pct = 0;  // receiver stall chance per cycle
  int unsigned hold_seq      = 0;  // bumped to start one long hold-off

  function automatic void clear_entry(idx_t m);
    mx_locked[m] = 1'b0;
    mx_cnf[m]    = 1'b0;
    mx_owner[m]  = '0;
    mx_qne[m]    = 1'b0;
  endfunction

  // apply one request to the lock table, return the status beat it produces
  function automatic rsp_t apply_request(opc_t op, idx_t m, tid_t t, logic plain);
    rsp_t r;
    tid_t h;
    r = '{status: mlm_pkg::ST_ERR, woken_valid: 1'b0, woken_thread: '0};
    case (op)
      mlm_pkg::OP_INIT: begin
        if (plain && !mx_init[m]) begin
          mx_init[m] = 1'b1;
          clear_entry(m);
          r.status = mlm_pkg::ST_OK;
        end
      end
      mlm_pkg::OP_LOCK, mlm_pkg::OP_TRYLOCK: begin
        if (mx_init[m]) begin
          if (!mx_locked[m]) begin
            mx_locked[m] = 1'b1;
            mx_cnf[m]    = 1'b0;
            mx_owner[m]  = t;
            r.status     = mlm_pkg::ST_OK;
          end else if (op == mlm_pkg::OP_TRYLOCK) begin
            // trylock leaves conflict alone
            r.status = mlm_pkg::ST_BUSY;
          end else begin
            // append to the wait queue, owner included
            mx_cnf[m] = 1'b1;
            if (mx_qne[m]) th_next[mx_tail[m]] = t;
            else mx_head[m] = t;
            mx_tail[m] = t;
            mx_qne[m]  = 1'b1;
            r.status   = mlm_pkg::ST_WAIT;
          end
        end
      end
      mlm_pkg::OP_UNLOCK: begin
        if (mx_init[m] && mx_locked[m] && mx_owner[m] == t) begin
          if (mx_qne[m]) begin
            // hand off to the queue head, conflict stays set
            h = mx_head[m];
            if (h == mx_tail[m]) mx_qne[m] = 1'b0;
            else mx_head[m] = th_next[h];
            mx_owner[m]    = h;
            r.woken_valid  = 1'b1;
            r.woken_thread = h;
          end else begin
            mx_locked[m] = 1'b0;
            mx_cnf[m]    = 1'b0;
            mx_owner[m]  = '0;
          end
          r.status = mlm_pkg::ST_OK;
        end
      end
      mlm_pkg::OP_DESTROY: begin
        if (mx_init[m] && (!mx_locked[m] || (mx_owner[m] == t && !mx_cnf[m]))) begin
          mx_init[m] = 1'b0;
          clear_entry(m);
          r.status = mlm_pkg::ST_OK;
        end
      end
      default: ;  // unknown operation: error, table untouched
    endcase
    return r;
  endfunction

  // offer one request beat, record what it owes once accepted
  task automatic send_request(opc_t op, idx_t m, tid_t t, logic plain, logic known,
                              logic [mlm_pkg::ST_W-1:0] status);
    rsp_t model_rsp;
    rsp_t typed_rsp;
    while ($urandom_range(99) < src_idle_pct) begin
      req_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_if.valid       <= 1'b1;
    req_if.operation   <= op;
    req_if.mutex_index <= m;
    req_if.thread_id   <= t;
    req_if.plain_type  <= plain;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    model_rsp = apply_request(op, m, t, plain);
    typed_rsp = '{status: status, woken_valid: 1'b0, woken_thread: '0};
    pending_rsp.push_back(known ? typed_rsp : model_rsp);
  endtask

  // sender pauses until every owed result has come back
  task automatic drain();
    req_if.valid <= 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk_i);
  endtask

  // one random phase: mostly a few hot mutexes and threads so queues build,
  // unlocks mostly by the owner so handoffs happen, the rest is noise
  task automatic run_phase(int unsigned src_pct, int unsigned snk_pct, bit hold);
    int unsigned n;
    int unsigned r;
    opc_t        op;
    idx_t        m;
    tid_t        t;
    logic        plain;
    src_idle_pct = src_pct;
    snk_stall_pct <= snk_pct;
    if (hold) hold_seq <= hold_seq + 1;
    for (n = 0; n < PHASE_BEATS; n++) begin
      m = ($urandom_range(9) < 8) ? idx_t'($urandom_range(3))
                                  : idx_t'($urandom_range(NUM_MX - 1));
      t = ($urandom_range(3) == 0) ? tid_t'($urandom_range(NUM_TH - 1))
                                   : tid_t'($urandom_range(5));
      plain = ($urandom_range(9) != 0);
      r = $urandom_range(99);
      if (!mx_init[m] && $urandom_range(3) != 0) begin
        op = mlm_pkg::OP_INIT;
      end else if (r < 35) begin
        op = mlm_pkg::OP_LOCK;
      end else if (r < 45) begin
        op = mlm_pkg::OP_TRYLOCK;
      end else if (r < 80) begin
        op = mlm_pkg::OP_UNLOCK;
        if ($urandom_range(99) < 85) t = mx_owner[m];
      end else if (r < 88) begin
        op = mlm_pkg::OP_INIT;
      end else if (r < 96) begin
        op = mlm_pkg::OP_DESTROY;
        if ($urandom_range(99) < 60) t = mx_owner[m];
      end else begin
        op = opc_t'($urandom_range(7, 5));
      end
      send_request(op, m, t, plain, PRED, mlm_pkg::ST_OK);
    end
    drain();
  endtask

  // receiver: random stalls, plus a long hold-off counted here on request
  initial begin : sink_side
    int unsigned hold_left;
    int unsigned hold_seen;
    hold_left = 0;
    hold_seen = 0;
    rsp_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_seq != hold_seen) begin
        hold_seen = hold_seq;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= ($urandom_range(99) >= snk_stall_pct);
      end
    end
  end

  // result checker: every accepted beat against the oldest owed result
  always @(posedge clk_i) begin : rsp_check
    rsp_t want;
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      if (pending_rsp.size() == 0) begin
        $error("result beat with nothing owed: status %0d woken %0d thread %0d",
               rsp_if.status, rsp_if.woken_valid, rsp_if.woken_thread);
        mismatch_cnt++;
      end else begin
        want = pending_rsp.pop_front();
        if (rsp_if.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, rsp_if.status);
          mismatch_cnt++;
        end
        if (rsp_if.woken_valid !== want.woken_valid) begin
          $error("woken_valid: expected %0d, got %0d", want.woken_valid,
                 rsp_if.woken_valid);
          mismatch_cnt++;
        end
        if (rsp_if.woken_thread !== want.woken_thread) begin
          $error("woken_thread: expected %0d, got %0d", want.woken_thread,
                 rsp_if.woken_thread);
          mismatch_cnt++;
        end
      end
    end
  end

  // main sequence: reset, directed table, then random phases with
  // different idle mixes; the last phase opens with the long hold-off
  initial begin : stimulus
    int unsigned i;
    req_if.valid       <= 1'b0;
    req_if.operation   <= mlm_pkg::OP_INIT;
    req_if.mutex_index <= '0;
    req_if.thread_id   <= '0;
    req_if.plain_type  <= 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (i = 0; i < N_DIRECTED; i++) begin
      send_request(DIRECTED[i].op, DIRECTED[i].mtx, DIRECTED[i].tid, DIRECTED[i].plain,
                   DIRECTED[i].known, DIRECTED[i].status);
    end
    drain();

    run_phase(0, 0, 1'b0);    // back to back
    run_phase(67, 0, 1'b0);   // sparse sender
    run_phase(0, 67, 1'b0);   // slow receiver
    run_phase(19, 19, 1'b0);  // both idle now and then
    run_phase(0, 0, 1'b1);    // receiver holds off while the sender keeps pushing

    // catch stray beats after the last expected one
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("mutex_lock_manager_fifo_handoff regression: pass");
    end else begin
      $display("mutex_lock_manager_fifo_handoff regression: fail");
    end
    $finish;
  end

  // hang guard, far beyond the slowest legal run
  initial begin : watchdog
    #2_000_000;
    $display("mutex_lock_manager_fifo_handoff regression: fail");
    $finish;
  end

endmodule
